### sv/tcw_pkg.sv
// Shared types, codes and constants of the text console writer.
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Widths that hold any legal geometry (up to 255 columns by 127 rows).
    localparam int COL_W  = 8;
    localparam int ROW_W  = 7;
    localparam int LIN_W  = 15;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    // Widths of the reported cursor fields.
    localparam int OUT_COL_W = 7;
    localparam int OUT_ROW_W = 5;
    localparam int OUT_LIN_W = 11;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

    typedef enum logic [2:0] {
        OP_PRINT    = 3'd0,
        OP_PUT_ATTR = 3'd1,
        OP_PUT_DEF  = 3'd2,
        OP_SET_CUR  = 3'd3,
        OP_CLEAR    = 3'd4,
        OP_READ     = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        K_NOP,
        K_CHAR,
        K_NEWLINE,
        K_RETURN,
        K_BACKSPACE,
        K_PUT,
        K_IGNORE,
        K_SET_CUR,
        K_CLEAR,
        K_READ
    } t_kind;

    typedef struct packed {
        logic [2:0]        operation;
        logic [7:0]        character;
        logic signed [7:0] col_in;
        logic signed [7:0] row_in;
        logic [7:0]        attribute;
    } t_in_item;

    typedef struct packed {
        logic [OUT_COL_W-1:0] out_col;
        logic [OUT_ROW_W-1:0] out_row;
        logic [OUT_LIN_W-1:0] cursor_linear;
        logic [CHAR_W-1:0]    read_char;
        logic [ATTR_W-1:0]    read_attr;
        logic                 scrolled;
        logic                 ignored;
    } t_out_item;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] character;
        logic [ATTR_W-1:0] attribute;
        logic              use_default;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [LIN_W-1:0]  lin;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

### sv/tcw_front.sv
// Front end: decodes an incoming item into a command for the execution side.
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  tcw_pkg::t_in_item i_item,
    output tcw_pkg::t_cmd     o_cmd
);

    logic                      col_neg;
    logic                      row_neg;
    logic [tcw_pkg::COL_W-1:0] col_u;
    logic [tcw_pkg::ROW_W-1:0] row_u;
    logic                      col_hi;
    logic                      row_hi;
    logic                      in_range;
    logic [tcw_pkg::COL_W-1:0] col_c;
    logic [tcw_pkg::ROW_W-1:0] row_c;

    assign col_neg  = i_item.col_in[7];
    assign row_neg  = i_item.row_in[7];
    assign col_u    = tcw_pkg::COL_W'(i_item.col_in[6:0]);
    assign row_u    = tcw_pkg::ROW_W'(i_item.row_in[6:0]);
    assign col_hi   = col_u >= tcw_pkg::COL_W'(COLUMNS);
    assign row_hi   = row_u >= tcw_pkg::ROW_W'(ROWS);
    assign in_range = !col_neg && !col_hi && !row_neg && !row_hi;

    // Clamped position; equal to the raw one whenever the item is in range.
    assign col_c = col_neg ? '0 : (col_hi ? tcw_pkg::COL_W'(COLUMNS - 1) : col_u);
    assign row_c = row_neg ? '0 : (row_hi ? tcw_pkg::ROW_W'(ROWS - 1) : row_u);

    always_comb begin
        o_cmd             = '0;
        o_cmd.kind        = tcw_pkg::K_NOP;
        o_cmd.character   = i_item.character;
        o_cmd.attribute   = i_item.attribute;
        o_cmd.use_default = 1'b1;
        o_cmd.col         = col_c;
        o_cmd.row         = row_c;
        o_cmd.lin         = tcw_pkg::LIN_W'(row_c) * tcw_pkg::LIN_W'(COLUMNS)
                          + tcw_pkg::LIN_W'(col_c);
        unique case (tcw_pkg::t_op'(i_item.operation))
            tcw_pkg::OP_PRINT: begin
                case (i_item.character)
                    tcw_pkg::CH_NEWLINE:   o_cmd.kind = tcw_pkg::K_NEWLINE;
                    tcw_pkg::CH_RETURN:    o_cmd.kind = tcw_pkg::K_RETURN;
                    tcw_pkg::CH_BACKSPACE: o_cmd.kind = tcw_pkg::K_BACKSPACE;
                    default:               o_cmd.kind = tcw_pkg::K_CHAR;
                endcase
            end
            tcw_pkg::OP_PUT_ATTR: begin
                o_cmd.kind        = in_range ? tcw_pkg::K_PUT : tcw_pkg::K_IGNORE;
                o_cmd.use_default = 1'b0;
            end
            tcw_pkg::OP_PUT_DEF: begin
                o_cmd.kind = in_range ? tcw_pkg::K_PUT : tcw_pkg::K_IGNORE;
            end
            tcw_pkg::OP_SET_CUR: o_cmd.kind = tcw_pkg::K_SET_CUR;
            tcw_pkg::OP_CLEAR:   o_cmd.kind = tcw_pkg::K_CLEAR;
            tcw_pkg::OP_READ: begin
                o_cmd.kind = in_range ? tcw_pkg::K_READ : tcw_pkg::K_IGNORE;
            end
            default: o_cmd.kind = tcw_pkg::K_NOP;
        endcase
    end

endmodule

### sv/tcw_queue.sv
// Two-entry command queue between the front end and the execution side.
module tcw_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tcw_pkg::t_cmd      i_wdata,
    input  logic               i_pop,
    output tcw_pkg::t_cmd      o_rdata,
    output tcw_pkg::t_q_status o_status
);

    tcw_pkg::t_cmd               r_slot [tcw_pkg::Q_DEPTH];
    logic [tcw_pkg::Q_PTR_W-1:0] r_wr;
    logic [tcw_pkg::Q_PTR_W-1:0] r_rd;
    logic [tcw_pkg::Q_CNT_W-1:0] r_count;
    logic [tcw_pkg::Q_PTR_W-1:0] n_wr;
    logic [tcw_pkg::Q_PTR_W-1:0] n_rd;
    logic [tcw_pkg::Q_CNT_W-1:0] n_count;

    localparam logic [tcw_pkg::Q_PTR_W-1:0] LAST = tcw_pkg::Q_PTR_W'(tcw_pkg::Q_DEPTH - 1);

    assign o_rdata         = r_slot[r_rd];
    assign o_status.empty  = r_count == '0;
    assign o_status.full   = r_count == tcw_pkg::Q_CNT_W'(tcw_pkg::Q_DEPTH);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_wdata;
        end
    end

endmodule

### sv/tcw_back.sv
// Execution side: cursor, cell store, scroll and clear sweeps, result register.
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tcw_pkg::t_cmd              i_cmd,
    input  tcw_pkg::t_q_status         i_q_status,
    input  logic [tcw_pkg::ATTR_W-1:0] i_default_attr,
    output logic                       o_pop,
    output logic                       o_done,
    output tcw_pkg::t_out_item         o_result
);

    localparam int CELLS    = ROWS * COLUMNS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int PTR_W    = $clog2(CELLS + 1);
    localparam int MOVE_END = (ROWS - 1) * COLUMNS - 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_MOVE  = 4'b0100,
        S_BLANK = 4'b1000
    } t_state;

    logic [tcw_pkg::CELL_W-1:0] mem [CELLS];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;

    t_state                    r_state, n_state;
    logic [tcw_pkg::COL_W-1:0] r_col, n_col;
    logic [tcw_pkg::ROW_W-1:0] r_row, n_row;
    logic [tcw_pkg::LIN_W-1:0] r_lin, n_lin;
    logic [PTR_W-1:0]          r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]          r_wr_ptr, n_wr_ptr;
    logic                      r_rd_valid, n_rd_valid;
    logic                      r_scroll, n_scroll;
    logic                      r_done, n_done;
    tcw_pkg::t_out_item        r_res, n_res;

    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic [tcw_pkg::CELL_W-1:0] blank;

    assign blank    = {i_default_attr, tcw_pkg::CH_BLANK};
    assign o_done   = r_done;
    assign o_result = r_res;

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_lin      = r_lin;
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_rd_valid = 1'b0;
        n_scroll   = r_scroll;
        n_done     = 1'b0;
        n_res      = '0;
        o_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = ADDR_W'(r_lin);
        mem_wdata  = blank;
        mem_raddr  = ADDR_W'(i_cmd.lin);

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop  = 1'b1;
                    n_done = 1'b1;
                    unique case (i_cmd.kind)
                        tcw_pkg::K_PUT: begin
                            mem_we    = 1'b1;
                            mem_waddr = ADDR_W'(i_cmd.lin);
                            mem_wdata = {i_cmd.use_default ? i_default_attr
                                                           : i_cmd.attribute,
                                         i_cmd.character};
                        end
                        tcw_pkg::K_IGNORE: n_res.ignored = 1'b1;
                        tcw_pkg::K_SET_CUR: begin
                            n_col = i_cmd.col;
                            n_row = i_cmd.row;
                            n_lin = i_cmd.lin;
                        end
                        tcw_pkg::K_CLEAR: begin
                            n_done   = 1'b0;
                            n_col    = '0;
                            n_row    = '0;
                            n_lin    = '0;
                            n_wr_ptr = '0;
                            n_scroll = 1'b0;
                            n_state  = S_BLANK;
                        end
                        tcw_pkg::K_READ: begin
                            n_done  = 1'b0;
                            n_state = S_READ;
                        end
                        tcw_pkg::K_CHAR: begin
                            mem_we    = 1'b1;
                            mem_wdata = {i_default_attr, i_cmd.character};
                            n_lin     = r_lin + 1'b1;
                            if (r_col == tcw_pkg::COL_W'(COLUMNS - 1)) begin
                                n_col = '0;
                                n_row = r_row + 1'b1;
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        tcw_pkg::K_NEWLINE: begin
                            n_col = '0;
                            n_row = r_row + 1'b1;
                            n_lin = r_lin - tcw_pkg::LIN_W'(r_col)
                                  + tcw_pkg::LIN_W'(COLUMNS);
                        end
                        tcw_pkg::K_RETURN: begin
                            n_col = '0;
                            n_lin = r_lin - tcw_pkg::LIN_W'(r_col);
                        end
                        tcw_pkg::K_BACKSPACE: begin
                            // Step back one cell, wrapping to the end of the row above.
                            if (r_col != '0 || r_row != '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = ADDR_W'(r_lin - 1'b1);
                                n_lin     = r_lin - 1'b1;
                                if (r_col != '0) begin
                                    n_col = r_col - 1'b1;
                                end else begin
                                    n_col = tcw_pkg::COL_W'(COLUMNS - 1);
                                    n_row = r_row - 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                    // Falling off the last row starts the scroll sweep.
                    if (n_row == tcw_pkg::ROW_W'(ROWS)) begin
                        n_done     = 1'b0;
                        n_row      = tcw_pkg::ROW_W'(ROWS - 1);
                        n_col      = '0;
                        n_lin      = tcw_pkg::LIN_W'((ROWS - 1) * COLUMNS);
                        n_rd_ptr   = PTR_W'(COLUMNS);
                        n_wr_ptr   = '0;
                        n_scroll   = 1'b1;
                        n_state    = S_MOVE;
                    end
                end
            end
            S_READ: begin
                n_done          = 1'b1;
                n_res.read_char = r_rdata[tcw_pkg::CHAR_W-1:0];
                n_res.read_attr = r_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                n_state         = S_IDLE;
            end
            S_MOVE: begin
                mem_raddr = r_rd_ptr[ADDR_W-1:0];
                if (r_rd_ptr != PTR_W'(CELLS)) begin
                    n_rd_ptr   = r_rd_ptr + 1'b1;
                    n_rd_valid = 1'b1;
                end
                if (r_rd_valid) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr_ptr[ADDR_W-1:0];
                    mem_wdata = r_rdata;
                    n_wr_ptr  = r_wr_ptr + 1'b1;
                    if (r_wr_ptr == PTR_W'(MOVE_END)) begin
                        n_state = S_BLANK;
                    end
                end
            end
            S_BLANK: begin
                mem_we    = 1'b1;
                mem_waddr = r_wr_ptr[ADDR_W-1:0];
                n_wr_ptr  = r_wr_ptr + 1'b1;
                if (r_wr_ptr == PTR_W'(CELLS - 1)) begin
                    n_done         = 1'b1;
                    n_res.scrolled = r_scroll;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_res.out_col       = tcw_pkg::OUT_COL_W'(n_col);
        n_res.out_row       = tcw_pkg::OUT_ROW_W'(n_row);
        n_res.cursor_linear = tcw_pkg::OUT_LIN_W'(n_lin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_col      <= '0;
            r_row      <= '0;
            r_lin      <= '0;
            r_rd_ptr   <= '0;
            r_wr_ptr   <= '0;
            r_rd_valid <= 1'b0;
            r_scroll   <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_lin      <= n_lin;
            r_rd_ptr   <= n_rd_ptr;
            r_wr_ptr   <= n_wr_ptr;
            r_rd_valid <= n_rd_valid;
            r_scroll   <= n_scroll;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

`ifndef NO_ASSERTIONS
    a_cursor_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < tcw_pkg::COL_W'(COLUMNS)) && (r_row < tcw_pkg::ROW_W'(ROWS)))
        else $error("cursor outside the screen");

    a_linear_tracks_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_lin == tcw_pkg::LIN_W'(r_row) * tcw_pkg::LIN_W'(COLUMNS)
                                         + tcw_pkg::LIN_W'(r_col)))
        else $error("linear cursor out of step with row and column");

    a_read_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> r_done)
        else $error("cell read gave no result");

    a_move_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE && r_rd_valid) |-> (r_rd_ptr == r_wr_ptr + PTR_W'(COLUMNS + 1)))
        else $error("scroll copy is not one row apart");
`endif

endmodule

### sv/text_console_writer.sv
// Top level of the text console writer: front end, command queue and execution side.
//
// Usage: an operation beat is taken at a rising edge with start high and busy low.
// The item's fields travel together on i_cmd. Each operation yields exactly one
// result beat, shown on o_result for a single cycle while o_done is high; the
// receiver has no way to hold it, so it must take the beat in that cycle.
// The default attribute is written through i_cfg_valid / o_cfg_ready / i_cfg_data
// and should change only while no operation is in flight.
// A taken item is registered in the queue and is popped once the execution side
// is idle; the execution side registers its result, and a cell read first passes
// through the read state, which takes the cell from the store's registered output.
// A print that runs past the last row adds a scroll sweep through the cell
// store's single write port: one copy per cycle over all rows but the last, then
// one blank per cycle over the bottom row. A clear blanks every cell, one per
// cycle. Items are executed one at a time in the order taken; a two-entry queue
// lets up to two items wait, and busy rises only while that queue is full.
// Reset puts the cursor at the top-left corner, sets the default attribute to
// white on black and empties the queue. The cell store itself is not cleared:
// issue a clear before reading cells that were never written.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  tcw_pkg::t_in_item          i_cmd,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0] i_cfg_data,
    output logic                       o_done,
    output tcw_pkg::t_out_item         o_result
);

    tcw_pkg::t_cmd              front_cmd;
    tcw_pkg::t_cmd              queue_cmd;
    tcw_pkg::t_q_status         q_status;
    logic                       push;
    logic                       pop;
    logic [tcw_pkg::ATTR_W-1:0] r_default_attr;

    // The attribute register is always ready to take a beat.
    assign o_cfg_ready = 1'b1;

    // The front end classifies in the accepting cycle; the queue holds the command.
    assign busy = q_status.full;
    assign push = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_attr <= tcw_pkg::ATTR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_default_attr <= i_cfg_data;
        end
    end

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_item (i_cmd),
        .o_cmd  (front_cmd)
    );

    tcw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  (front_cmd),
        .i_pop    (pop),
        .o_rdata  (queue_cmd),
        .o_status (q_status)
    );

    // The execution side owns the cursor and the cell store and forms each result.
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (queue_cmd),
        .i_q_status     (q_status),
        .i_default_attr (r_default_attr),
        .o_pop          (pop),
        .o_done         (o_done),
        .o_result       (o_result)
    );

endmodule
